### design/cpmi_pkg.sv
`timescale 1ns / 1ps

package cpmi_pkg;

	// Action codes carried by an input item.
	typedef enum logic [1:0] {
		ACT_TICK     = 2'd0,
		ACT_SET      = 2'd1,
		ACT_MOVE_CUR = 2'd2,
		ACT_MOVE_ORG = 2'd3
	} action_t;

	// Configuration register indexes.
	localparam logic [2:0] CFG_X_LO  = 3'd0;
	localparam logic [2:0] CFG_X_HI  = 3'd1;
	localparam logic [2:0] CFG_Y_LO  = 3'd2;
	localparam logic [2:0] CFG_Y_HI  = 3'd3;
	localparam logic [2:0] CFG_Z_LO  = 3'd4;
	localparam logic [2:0] CFG_Z_HI  = 3'd5;
	localparam logic [2:0] CFG_CEIL  = 3'd6;
	localparam logic [2:0] CFG_FLOOR = 3'd7;

	// Arithmetic constants.
	localparam longint ONE_Q30 = 64'sd1073741824;
	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam logic [19:0] USEC_PER_S = 20'd1000000;
	localparam logic [24:0] FRAC_ONE = 25'h1000000;
	localparam logic [5:0] SQRT_LAST = 6'd32;
	localparam logic [5:0] DIV_LAST = 6'd39;
	localparam logic [31:0] RATE_MAX = 32'hFFFF_FFFF;
	localparam logic [31:0] RATE_MIN = 32'd1;
	localparam logic [30:0] CEIL_RESET = 31'd5898240;
	localparam logic [30:0] FLOOR_RESET = 31'd327680;

	typedef struct packed {
		action_t            action;
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
		logic signed [31:0] target_e;
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] origin_e;
		logic [30:0]        speed;
		logic [31:0]        now_us;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] pos_e;
		logic               finished;
		logic               status;
		logic               done_event;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] x_lo;
		logic signed [31:0] x_hi;
		logic signed [31:0] y_lo;
		logic signed [31:0] y_hi;
		logic signed [31:0] z_lo;
		logic signed [31:0] z_hi;
		logic [30:0]        ceiling;
		logic [30:0]        floor_v;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DECODE, ST_SQ_X, ST_SQ_Y, ST_SQ_Z, ST_SQ_ACC, ST_SQRT_D,
		ST_DIST, ST_FINISH_NOW, ST_SQRT_V_INIT, ST_SQRT_V, ST_SPEED, ST_DEN,
		ST_DIV_INIT, ST_DIV, ST_ARM, ST_T_PHASE, ST_T_CHECK, ST_T_RD, ST_T_LO,
		ST_T_HI, ST_T_PROG, ST_AX_X, ST_AX_Y, ST_AX_Z, ST_AX_E, ST_AX_WB, ST_OUT
	} state_t;

	typedef enum logic [4:0] {
		CMD_NONE, CMD_LOAD, CMD_DECODE, CMD_SQ_X, CMD_SQ_Y, CMD_SQ_Z, CMD_SQ_ACC,
		CMD_SQRT_STEP, CMD_DIST, CMD_FINISH_NOW, CMD_SQRT_V_INIT, CMD_SPEED,
		CMD_DEN, CMD_DIV_INIT, CMD_DIV_STEP, CMD_ARM, CMD_T_PHASE, CMD_T_SCALE,
		CMD_T_END, CMD_T_RD, CMD_T_LO, CMD_T_HI, CMD_T_PROG, CMD_AX_X, CMD_AX_Y,
		CMD_AX_Z, CMD_AX_E, CMD_AX_WB, CMD_OUT
	} dp_cmd_t;

	typedef struct packed {
		action_t action;
		logic    moving;
		logic    reject;
		logic    dist_zero;
		logic    req_zero;
		logic    div_sat;
		logic    iter_last;
		logic    phase_done;
		logic    out_free;
	} dp_status_t;

	// Cosine in Q1.30 by a nested Taylor series of degree 14.
	function automatic logic [30:0] cos_q30(input longint unsigned theta);
		longint unsigned t2;
		longint unsigned bb;
		longint b;
		t2 = (theta * theta) >> 30;
		b = ONE_Q30;
		bb = (b < 0) ? 64'd0 : longint'(b);
		b = ONE_Q30 - longint'(((t2 * bb) >> 30) / 64'd182);
		bb = (b < 0) ? 64'd0 : longint'(b);
		b = ONE_Q30 - longint'(((t2 * bb) >> 30) / 64'd132);
		bb = (b < 0) ? 64'd0 : longint'(b);
		b = ONE_Q30 - longint'(((t2 * bb) >> 30) / 64'd90);
		bb = (b < 0) ? 64'd0 : longint'(b);
		b = ONE_Q30 - longint'(((t2 * bb) >> 30) / 64'd56);
		bb = (b < 0) ? 64'd0 : longint'(b);
		b = ONE_Q30 - longint'(((t2 * bb) >> 30) / 64'd30);
		bb = (b < 0) ? 64'd0 : longint'(b);
		b = ONE_Q30 - longint'(((t2 * bb) >> 30) / 64'd12);
		bb = (b < 0) ? 64'd0 : longint'(b);
		b = ONE_Q30 - longint'(((t2 * bb) >> 30) / 64'd2);
		if (b < 0) b = 0;
		if (b > ONE_Q30) b = ONE_Q30;
		return b[30:0];
	endfunction

endpackage

### design/cpmi_ctrl.sv
`timescale 1ns / 1ps

module cpmi_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  cpmi_pkg::dp_status_t st,
	output cpmi_pkg::dp_cmd_t    cmd,
	output logic                 in_stall
);

	cpmi_pkg::state_t state_q;
	cpmi_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpmi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cpmi_pkg::ST_IDLE: begin
				if (in_valid) state_d = cpmi_pkg::ST_DECODE;
			end
			cpmi_pkg::ST_DECODE: begin
				if (st.action == cpmi_pkg::ACT_TICK) begin
					state_d = st.moving ? cpmi_pkg::ST_T_PHASE : cpmi_pkg::ST_OUT;
				end else if (st.action == cpmi_pkg::ACT_SET || st.reject) begin
					state_d = cpmi_pkg::ST_OUT;
				end else begin
					state_d = cpmi_pkg::ST_SQ_X;
				end
			end
			cpmi_pkg::ST_SQ_X:   state_d = cpmi_pkg::ST_SQ_Y;
			cpmi_pkg::ST_SQ_Y:   state_d = cpmi_pkg::ST_SQ_Z;
			cpmi_pkg::ST_SQ_Z:   state_d = cpmi_pkg::ST_SQ_ACC;
			cpmi_pkg::ST_SQ_ACC: state_d = cpmi_pkg::ST_SQRT_D;
			cpmi_pkg::ST_SQRT_D: begin
				if (st.iter_last) state_d = cpmi_pkg::ST_DIST;
			end
			cpmi_pkg::ST_DIST: begin
				if (st.dist_zero) state_d = cpmi_pkg::ST_FINISH_NOW;
				else if (st.req_zero) state_d = cpmi_pkg::ST_SQRT_V_INIT;
				else state_d = cpmi_pkg::ST_SPEED;
			end
			cpmi_pkg::ST_FINISH_NOW:  state_d = cpmi_pkg::ST_OUT;
			cpmi_pkg::ST_SQRT_V_INIT: state_d = cpmi_pkg::ST_SQRT_V;
			cpmi_pkg::ST_SQRT_V: begin
				if (st.iter_last) state_d = cpmi_pkg::ST_SPEED;
			end
			cpmi_pkg::ST_SPEED: state_d = cpmi_pkg::ST_DEN;
			cpmi_pkg::ST_DEN:   state_d = cpmi_pkg::ST_DIV_INIT;
			cpmi_pkg::ST_DIV_INIT: begin
				state_d = st.div_sat ? cpmi_pkg::ST_ARM : cpmi_pkg::ST_DIV;
			end
			cpmi_pkg::ST_DIV: begin
				if (st.iter_last) state_d = cpmi_pkg::ST_ARM;
			end
			cpmi_pkg::ST_ARM:     state_d = cpmi_pkg::ST_OUT;
			cpmi_pkg::ST_T_PHASE: state_d = cpmi_pkg::ST_T_CHECK;
			cpmi_pkg::ST_T_CHECK: begin
				state_d = st.phase_done ? cpmi_pkg::ST_OUT : cpmi_pkg::ST_T_RD;
			end
			cpmi_pkg::ST_T_RD:   state_d = cpmi_pkg::ST_T_LO;
			cpmi_pkg::ST_T_LO:   state_d = cpmi_pkg::ST_T_HI;
			cpmi_pkg::ST_T_HI:   state_d = cpmi_pkg::ST_T_PROG;
			cpmi_pkg::ST_T_PROG: state_d = cpmi_pkg::ST_AX_X;
			cpmi_pkg::ST_AX_X:   state_d = cpmi_pkg::ST_AX_Y;
			cpmi_pkg::ST_AX_Y:   state_d = cpmi_pkg::ST_AX_Z;
			cpmi_pkg::ST_AX_Z:   state_d = cpmi_pkg::ST_AX_E;
			cpmi_pkg::ST_AX_E:   state_d = cpmi_pkg::ST_AX_WB;
			cpmi_pkg::ST_AX_WB:  state_d = cpmi_pkg::ST_OUT;
			cpmi_pkg::ST_OUT: begin
				if (st.out_free) state_d = cpmi_pkg::ST_IDLE;
			end
			default: state_d = cpmi_pkg::ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd = cpmi_pkg::CMD_NONE;
		in_stall = 1'b1;
		unique case (state_q)
			cpmi_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) cmd = cpmi_pkg::CMD_LOAD;
			end
			cpmi_pkg::ST_DECODE:      cmd = cpmi_pkg::CMD_DECODE;
			cpmi_pkg::ST_SQ_X:        cmd = cpmi_pkg::CMD_SQ_X;
			cpmi_pkg::ST_SQ_Y:        cmd = cpmi_pkg::CMD_SQ_Y;
			cpmi_pkg::ST_SQ_Z:        cmd = cpmi_pkg::CMD_SQ_Z;
			cpmi_pkg::ST_SQ_ACC:      cmd = cpmi_pkg::CMD_SQ_ACC;
			cpmi_pkg::ST_SQRT_D:      cmd = cpmi_pkg::CMD_SQRT_STEP;
			cpmi_pkg::ST_DIST:        cmd = cpmi_pkg::CMD_DIST;
			cpmi_pkg::ST_FINISH_NOW:  cmd = cpmi_pkg::CMD_FINISH_NOW;
			cpmi_pkg::ST_SQRT_V_INIT: cmd = cpmi_pkg::CMD_SQRT_V_INIT;
			cpmi_pkg::ST_SQRT_V:      cmd = cpmi_pkg::CMD_SQRT_STEP;
			cpmi_pkg::ST_SPEED:       cmd = cpmi_pkg::CMD_SPEED;
			cpmi_pkg::ST_DEN:         cmd = cpmi_pkg::CMD_DEN;
			cpmi_pkg::ST_DIV_INIT:    cmd = cpmi_pkg::CMD_DIV_INIT;
			cpmi_pkg::ST_DIV:         cmd = cpmi_pkg::CMD_DIV_STEP;
			cpmi_pkg::ST_ARM:         cmd = cpmi_pkg::CMD_ARM;
			cpmi_pkg::ST_T_PHASE:     cmd = cpmi_pkg::CMD_T_PHASE;
			cpmi_pkg::ST_T_CHECK: begin
				cmd = st.phase_done ? cpmi_pkg::CMD_T_END : cpmi_pkg::CMD_T_SCALE;
			end
			cpmi_pkg::ST_T_RD:   cmd = cpmi_pkg::CMD_T_RD;
			cpmi_pkg::ST_T_LO:   cmd = cpmi_pkg::CMD_T_LO;
			cpmi_pkg::ST_T_HI:   cmd = cpmi_pkg::CMD_T_HI;
			cpmi_pkg::ST_T_PROG: cmd = cpmi_pkg::CMD_T_PROG;
			cpmi_pkg::ST_AX_X:   cmd = cpmi_pkg::CMD_AX_X;
			cpmi_pkg::ST_AX_Y:   cmd = cpmi_pkg::CMD_AX_Y;
			cpmi_pkg::ST_AX_Z:   cmd = cpmi_pkg::CMD_AX_Z;
			cpmi_pkg::ST_AX_E:   cmd = cpmi_pkg::CMD_AX_E;
			cpmi_pkg::ST_AX_WB:  cmd = cpmi_pkg::CMD_AX_WB;
			cpmi_pkg::ST_OUT:    cmd = cpmi_pkg::CMD_OUT;
			default:             cmd = cpmi_pkg::CMD_NONE;
		endcase
	end

endmodule

### design/cpmi_dp.sv
`timescale 1ns / 1ps

module cpmi_dp #(
	parameter int unsigned COSINE_TABLE_DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cpmi_pkg::dp_cmd_t     cmd,
	input  cpmi_pkg::in_item_t    in_data,
	input  cpmi_pkg::cfg_t        cfg,
	input  logic                  out_stall,
	output logic                  out_valid,
	output cpmi_pkg::out_item_t   out_data,
	output cpmi_pkg::dp_status_t  st
);

	localparam int unsigned IW = $clog2(COSINE_TABLE_DEPTH);
	localparam int unsigned AW = $clog2(COSINE_TABLE_DEPTH + 1);
	localparam int unsigned DW = $clog2(COSINE_TABLE_DEPTH + 1);
	localparam logic [DW-1:0] DEPTH_V = DW'(COSINE_TABLE_DEPTH);

	typedef logic [30:0] rom_t [COSINE_TABLE_DEPTH+1];

	// Raised-cosine profile points, mirrored about the midpoint.
	function automatic rom_t build_rom();
		rom_t t;
		longint unsigned m;
		longint unsigned r;
		logic low;
		for (int k = 0; k <= COSINE_TABLE_DEPTH; k++) begin
			low = (2 * k <= COSINE_TABLE_DEPTH);
			m = low ? longint'(k) : longint'(COSINE_TABLE_DEPTH - k);
			r = longint'(cpmi_pkg::ONE_Q30 -
				longint'(cpmi_pkg::cos_q30(cpmi_pkg::PI_Q30 * m / COSINE_TABLE_DEPTH))) >> 1;
			t[k] = low ? r[30:0] : 31'(longint'(cpmi_pkg::ONE_Q30) - longint'(r));
		end
		return t;
	endfunction

	localparam rom_t PROFILE_ROM = build_rom();

	// Architectural state.
	logic signed [31:0] start_q [4];
	logic signed [32:0] delta_q [4];
	logic signed [31:0] cur_q [4];
	logic [31:0]        rate_q;
	logic [31:0]        stamp_q;
	logic               moving_q;
	logic               status_q;
	logic               done_q;
	logic               out_valid_q;
	cpmi_pkg::out_item_t out_q;

	// Working registers.
	cpmi_pkg::in_item_t item_q;
	logic [64:0]        prod_q;
	logic [65:0]        acc_q;
	logic [65:0]        rad_q;
	logic [34:0]        rem_q;
	logic [32:0]        res_q;
	logic [5:0]         cnt_q;
	logic [32:0]        dist_q;
	logic [30:0]        v_q;
	logic [52:0]        den_q;
	logic [53:0]        r_q;
	logic [39:0]        quo_q;
	logic               sat_q;
	logic [IW-1:0]      idx_q;
	logic [23:0]        frac_q;
	logic [30:0]        rom_q;
	logic [30:0]        prog_q;

	logic signed [31:0] tgt [4];
	logic signed [31:0] org [4];
	logic signed [32:0] dnew [4];
	logic [31:0]        mag_d [4];
	logic               reject;
	logic               is_move;
	logic [32:0]        mul_a;
	logic [31:0]        mul_b;
	logic               mul_en;
	logic [36:0]        rem_sh;
	logic [36:0]        trial;
	logic [32:0]        dist_d;
	logic [35:0]        auto_v;
	logic [30:0]        auto_f;
	logic [30:0]        v_pre;
	logic [30:0]        v_d;
	logic [53:0]        r2;
	logic [39+DW:0]     scaled;
	logic [AW-1:0]      rom_addr;
	logic [65:0]        sum_acc;
	logic [64:0]        ax_sum;
	logic [31:0]        ax_q;
	logic [1:0]         wb_k;
	logic signed [31:0] ax_new;
	logic               out_free;
	logic [31:0]        elapsed;

	// Per-axis operands of the current item.
	always_comb begin
		tgt[0] = item_q.target_x;
		tgt[1] = item_q.target_y;
		tgt[2] = item_q.target_z;
		tgt[3] = item_q.target_e;
		for (int k = 0; k < 4; k++) begin
			if (item_q.action == cpmi_pkg::ACT_MOVE_ORG) begin
				org[k] = (k == 0) ? item_q.origin_x : (k == 1) ? item_q.origin_y :
					(k == 2) ? item_q.origin_z : item_q.origin_e;
			end else begin
				org[k] = start_q[k] + delta_q[k][31:0];
			end
			dnew[k] = 33'(tgt[k]) - 33'(org[k]);
			mag_d[k] = delta_q[k][32] ? 32'(-delta_q[k]) : delta_q[k][31:0];
		end
	end

	// Reach check on the target box.
	always_comb begin
		is_move = (item_q.action == cpmi_pkg::ACT_MOVE_CUR) ||
			(item_q.action == cpmi_pkg::ACT_MOVE_ORG);
		reject = (item_q.target_x > cfg.x_hi) || (item_q.target_x < cfg.x_lo) ||
			(item_q.target_y > cfg.y_hi) || (item_q.target_y < cfg.y_lo) ||
			(item_q.target_z > cfg.z_hi) || (item_q.target_z < cfg.z_lo);
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		mul_en = 1'b1;
		unique case (cmd)
			cpmi_pkg::CMD_SQ_X: begin mul_a = {1'b0, mag_d[0]}; mul_b = mag_d[0]; end
			cpmi_pkg::CMD_SQ_Y: begin mul_a = {1'b0, mag_d[1]}; mul_b = mag_d[1]; end
			cpmi_pkg::CMD_SQ_Z: begin mul_a = {1'b0, mag_d[2]}; mul_b = mag_d[2]; end
			cpmi_pkg::CMD_DEN: begin
				mul_a = dist_q;
				mul_b = {12'b0, cpmi_pkg::USEC_PER_S};
			end
			cpmi_pkg::CMD_T_PHASE: begin mul_a = {1'b0, elapsed}; mul_b = rate_q; end
			cpmi_pkg::CMD_T_LO: begin
				mul_a = {2'b0, rom_q};
				mul_b = {7'b0, cpmi_pkg::FRAC_ONE - {1'b0, frac_q}};
			end
			cpmi_pkg::CMD_T_HI: begin mul_a = {2'b0, rom_q}; mul_b = {8'b0, frac_q}; end
			cpmi_pkg::CMD_AX_X: begin mul_a = {1'b0, mag_d[0]}; mul_b = {1'b0, prog_q}; end
			cpmi_pkg::CMD_AX_Y: begin mul_a = {1'b0, mag_d[1]}; mul_b = {1'b0, prog_q}; end
			cpmi_pkg::CMD_AX_Z: begin mul_a = {1'b0, mag_d[2]}; mul_b = {1'b0, prog_q}; end
			cpmi_pkg::CMD_AX_E: begin mul_a = {1'b0, mag_d[3]}; mul_b = {1'b0, prog_q}; end
			default: mul_en = 1'b0;
		endcase
	end

	// Square root step, speed choice, division step and table scaling.
	always_comb begin
		elapsed = item_q.now_us - stamp_q;
		rem_sh = {rem_q, rad_q[65:64]};
		trial = {2'b0, res_q, 2'b01};
		dist_d = (res_q < {1'b0, mag_d[3]}) ? {1'b0, mag_d[3]} : res_q;
		auto_v = {res_q, 3'b0} + {2'b0, res_q, 1'b0};
		auto_f = (auto_v[30:0] < cfg.floor_v) ? cfg.floor_v : auto_v[30:0];
		v_pre = (item_q.speed == '0) ? auto_f : item_q.speed;
		v_d = (v_pre > cfg.ceiling) ? cfg.ceiling : v_pre;
		r2 = {r_q[52:0], 1'b0};
		scaled = prod_q[39:0] * DEPTH_V;
		rom_addr = (cmd == cpmi_pkg::CMD_T_LO) ? AW'(idx_q) + AW'(1) : AW'(idx_q);
		sum_acc = acc_q + {1'b0, prod_q};
		out_free = !out_valid_q || !out_stall;
	end

	// Axis offset from the last product, rounded half away from zero.
	always_comb begin
		unique case (cmd)
			cpmi_pkg::CMD_AX_Y: wb_k = 2'd0;
			cpmi_pkg::CMD_AX_Z: wb_k = 2'd1;
			cpmi_pkg::CMD_AX_E: wb_k = 2'd2;
			default:            wb_k = 2'd3;
		endcase
		ax_sum = prod_q + 65'(1 << 29);
		ax_q = ax_sum[61:30];
		ax_new = delta_q[wb_k][32] ? start_q[wb_k] - ax_q : start_q[wb_k] + ax_q;
	end

	// Profile table read port.
	always_ff @(posedge clk) begin
		rom_q <= PROFILE_ROM[rom_addr];
	end

	// Working registers, sequenced by the controller.
	always_ff @(posedge clk) begin
		if (mul_en) prod_q <= 65'(mul_a) * 65'(mul_b);
		unique case (cmd)
			cpmi_pkg::CMD_LOAD:   item_q <= in_data;
			cpmi_pkg::CMD_SQ_Y:   acc_q <= {1'b0, prod_q};
			cpmi_pkg::CMD_SQ_Z:   acc_q <= sum_acc;
			cpmi_pkg::CMD_SQ_ACC: begin
				rad_q <= sum_acc;
				rem_q <= '0;
				res_q <= '0;
				cnt_q <= cpmi_pkg::SQRT_LAST;
			end
			cpmi_pkg::CMD_SQRT_STEP: begin
				if (rem_sh >= trial) begin
					rem_q <= 35'(rem_sh - trial);
					res_q <= {res_q[31:0], 1'b1};
				end else begin
					rem_q <= rem_sh[34:0];
					res_q <= {res_q[31:0], 1'b0};
				end
				rad_q <= {rad_q[63:0], 2'b0};
				cnt_q <= cnt_q - 6'd1;
			end
			cpmi_pkg::CMD_DIST: dist_q <= dist_d;
			cpmi_pkg::CMD_SQRT_V_INIT: begin
				rad_q <= {17'b0, dist_q, 16'b0};
				rem_q <= '0;
				res_q <= '0;
				cnt_q <= cpmi_pkg::SQRT_LAST;
			end
			cpmi_pkg::CMD_SPEED: v_q <= v_d;
			cpmi_pkg::CMD_DIV_INIT: begin
				den_q <= prod_q[52:0];
				r_q <= {23'b0, v_q};
				quo_q <= '0;
				sat_q <= ({34'b0, v_q} >= prod_q);
				cnt_q <= cpmi_pkg::DIV_LAST;
			end
			cpmi_pkg::CMD_DIV_STEP: begin
				if (r2 >= {1'b0, den_q}) begin
					r_q <= r2 - {1'b0, den_q};
					quo_q <= {quo_q[38:0], 1'b1};
				end else begin
					r_q <= r2;
					quo_q <= {quo_q[38:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
			end
			cpmi_pkg::CMD_T_SCALE: begin
				idx_q <= scaled[40 +: IW];
				frac_q <= scaled[39:16];
			end
			cpmi_pkg::CMD_T_HI:   acc_q <= {1'b0, prod_q};
			cpmi_pkg::CMD_T_PROG: prog_q <= sum_acc[54:24];
			default: ;
		endcase
	end

	// Motion state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) begin
				start_q[k] <= '0;
				delta_q[k] <= '0;
				cur_q[k] <= '0;
			end
			rate_q <= '0;
			stamp_q <= '0;
			moving_q <= 1'b0;
			status_q <= 1'b0;
			done_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd == cpmi_pkg::CMD_OUT && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (cmd)
				cpmi_pkg::CMD_DECODE: begin
					status_q <= is_move && reject;
					done_q <= 1'b0;
					if (item_q.action == cpmi_pkg::ACT_SET) begin
						for (int k = 0; k < 4; k++) begin
							start_q[k] <= tgt[k];
							delta_q[k] <= '0;
						end
					end else if (is_move && !reject) begin
						for (int k = 0; k < 4; k++) begin
							start_q[k] <= org[k];
							delta_q[k] <= dnew[k];
						end
					end
				end
				cpmi_pkg::CMD_FINISH_NOW: begin
					for (int k = 0; k < 4; k++) cur_q[k] <= tgt[k];
					rate_q <= '0;
					moving_q <= 1'b0;
					done_q <= 1'b1;
				end
				cpmi_pkg::CMD_ARM: begin
					if (sat_q || quo_q[39:32] != '0) rate_q <= cpmi_pkg::RATE_MAX;
					else if (quo_q[31:0] == '0) rate_q <= cpmi_pkg::RATE_MIN;
					else rate_q <= quo_q[31:0];
					stamp_q <= item_q.now_us;
					moving_q <= 1'b1;
				end
				cpmi_pkg::CMD_T_END: begin
					for (int k = 0; k < 4; k++) cur_q[k] <= start_q[k] + delta_q[k][31:0];
					moving_q <= 1'b0;
					done_q <= 1'b1;
				end
				cpmi_pkg::CMD_AX_Y, cpmi_pkg::CMD_AX_Z, cpmi_pkg::CMD_AX_E,
				cpmi_pkg::CMD_AX_WB: begin
					cur_q[wb_k] <= ax_new;
				end
				default: ;
			endcase
		end
	end

	// Result payload, captured with the transfer into the output register.
	always_ff @(posedge clk) begin
		if (cmd == cpmi_pkg::CMD_OUT && out_free) begin
			out_q.pos_x <= cur_q[0];
			out_q.pos_y <= cur_q[1];
			out_q.pos_z <= cur_q[2];
			out_q.pos_e <= cur_q[3];
			out_q.finished <= !moving_q;
			out_q.status <= status_q;
			out_q.done_event <= done_q;
		end
	end

	// Status back to the controller.
	always_comb begin
		st.action = item_q.action;
		st.moving = moving_q;
		st.reject = reject;
		st.dist_zero = (dist_d == '0);
		st.req_zero = (item_q.speed == '0);
		st.div_sat = ({34'b0, v_q} >= prod_q);
		st.iter_last = (cnt_q == '0);
		st.phase_done = (prod_q[64:40] != '0);
		st.out_free = out_free;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

### design/cosine_ptp_motion_interpolator_top.sv
`timescale 1ns / 1ps

// Four-axis point-to-point planner with a raised-cosine position profile.
// Input channel in_valid/in_stall/in_data carries one item: a tick, a set
// position or a move. Every item gives exactly one result on the output
// channel out_valid/out_stall/out_data: the current position, the finished
// flag, the reach status and the done flag.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user
// must do so only while idle, as the block itself does not enforce it.
// One item is worked at a time; in_stall is low only while the block waits.
// A set position, an idle tick or a rejected move is decoded and answered;
// a tick in motion finds its phase and, unless the move ends there, reads
// the table twice and scales each axis on the shared multiplier. An accepted
// move runs the one-bit-per-cycle square root unit (33 steps, run twice for
// automatic speed) and the 40-step divider. The result waits in an output
// register; while out_stall is high the block can still take the next
// item, and holds its result until the register is free. Reset returns
// the limits and speeds to their defaults, clears the position and plan
// and leaves the block idle.
module cosine_ptp_motion_interpolator_top #(
	parameter int unsigned COSINE_TABLE_DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  cpmi_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output cpmi_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	cpmi_pkg::cfg_t       cfg_q;
	cpmi_pkg::dp_cmd_t    cmd;
	cpmi_pkg::dp_status_t st;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_lo <= 32'sh8000_0000;
			cfg_q.x_hi <= 32'sh7FFF_FFFF;
			cfg_q.y_lo <= 32'sh8000_0000;
			cfg_q.y_hi <= 32'sh7FFF_FFFF;
			cfg_q.z_lo <= 32'sh8000_0000;
			cfg_q.z_hi <= 32'sh7FFF_FFFF;
			cfg_q.ceiling <= cpmi_pkg::CEIL_RESET;
			cfg_q.floor_v <= cpmi_pkg::FLOOR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cpmi_pkg::CFG_X_LO:  cfg_q.x_lo <= cfg_data;
				cpmi_pkg::CFG_X_HI:  cfg_q.x_hi <= cfg_data;
				cpmi_pkg::CFG_Y_LO:  cfg_q.y_lo <= cfg_data;
				cpmi_pkg::CFG_Y_HI:  cfg_q.y_hi <= cfg_data;
				cpmi_pkg::CFG_Z_LO:  cfg_q.z_lo <= cfg_data;
				cpmi_pkg::CFG_Z_HI:  cfg_q.z_hi <= cfg_data;
				cpmi_pkg::CFG_CEIL:  cfg_q.ceiling <= cfg_data[30:0];
				cpmi_pkg::CFG_FLOOR: cfg_q.floor_v <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	cpmi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.st       (st),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	cpmi_dp #(
		.COSINE_TABLE_DEPTH (COSINE_TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.st        (st)
	);

endmodule
